FILE: rtl/core/sliding_window_linear_fit_macros.svh
// ----------------------------------------------------------------------------
// Sliding window linear fit: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_LINEAR_FIT_MACROS_SVH
`define SLIDING_WINDOW_LINEAR_FIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWLF_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWLF_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/swlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlf_pkg
// Constants, widths, lookup tables and types of the sliding window fit.
// ----------------------------------------------------------------------------
package swlf_pkg;

  localparam int WINDOW   = 32;
  localparam int SAMPLE_W = 24;
  localparam int RESULT_W = 48;
  localparam int FRAC_W   = 16;

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int WIN_LOG = $clog2(WINDOW);

  localparam int SX_MAX  = WINDOW * (WINDOW + 1) / 2;
  localparam int SX_W    = $clog2(SX_MAX + 1);
  localparam int DEN_MAX = WINDOW * WINDOW * (WINDOW * WINDOW - 1) / 12;
  localparam int DEN_W   = $clog2(DEN_MAX + 1);

  localparam int SY_W  = SAMPLE_W + WIN_LOG + 1;
  localparam int SXY_W = SAMPLE_W + SX_W + 1;
  localparam int NUM_W = SXY_W + WIN_LOG + 1;
  localparam int A_W   = NUM_W + SX_W + 2;

  localparam int DVD_W = A_W + FRAC_W;
  localparam int DVS_W = DEN_W + WIN_LOG + 1;
  localparam int CNT_W = $clog2(DVD_W + 1);

  typedef logic [SX_W-1:0]  sx_tab_t  [WINDOW+1];
  typedef logic [DEN_W-1:0] den_tab_t [WINDOW+1];

  function automatic sx_tab_t gen_sx_tab();
    sx_tab_t t;
    for (int i = 0; i <= WINDOW; i++) begin
      t[i] = SX_W'(i * (i + 1) / 2);
    end
    return t;
  endfunction

  function automatic den_tab_t gen_den_tab();
    den_tab_t t;
    int sx;
    int sxx;
    for (int i = 0; i <= WINDOW; i++) begin
      sx   = i * (i + 1) / 2;
      sxx  = i * (i + 1) * (2 * i + 1) / 6;
      t[i] = DEN_W'(WINDOW * sxx - sx * sx);
    end
    return t;
  endfunction

  localparam sx_tab_t  SX_TAB  = gen_sx_tab();
  localparam den_tab_t DEN_TAB = gen_den_tab();

  // One fit job handed from the front end to the division back end.
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [A_W-1:0]   a;
    logic [DEN_W-1:0]        den;
  } job_t;

endpackage

FILE: rtl/core/swlf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlf_front
// Window store, running sums and numerator terms of each fit.
// ----------------------------------------------------------------------------
module swlf_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  input  logic signed [swlf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                               busy_o,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output swlf_pkg::job_t                     q_data_o
);
  import swlf_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_SUM, F_NUM, F_PROD, F_AFIN} state_e;

  state_e                     state_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [SLOT_W-1:0]          oldest_q, oldest_d;
  logic signed [SY_W-1:0]     sy_q, sy_d;
  logic signed [SXY_W-1:0]    sxy_q, sxy_d;
  logic signed [NUM_W-1:0]    num_q;
  logic signed [A_W-1:0]      prod_q;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic signed [SAMPLE_W-1:0] mem [WINDOW];

  logic                       win_full;
  logic [SLOT_W-1:0]          wr_addr;
  logic signed [SXY_W-1:0]    fill_term;
  logic [SX_W-1:0]            sx;
  logic [DEN_W-1:0]           den;
  logic signed [SXY_W+WIN_LOG:0] num_full;
  logic signed [A_W-1:0]      a_val;

  assign win_full = (fill_q == FILL_W'(WINDOW));
  assign wr_addr  = win_full ? oldest_q : fill_q[SLOT_W-1:0];
  assign sx       = SX_TAB[fill_q];
  assign den      = DEN_TAB[fill_q];

  always_comb begin
    fill_d    = fill_q;
    oldest_d  = oldest_q;
    fill_term = SXY_W'($signed({1'b0, fill_q + FILL_W'(1)}) * sample_q);
    if (!win_full) begin
      fill_d = fill_q + FILL_W'(1);
      sy_d   = sy_q + SY_W'(sample_q);
      sxy_d  = sxy_q + fill_term;
    end else begin
      sy_d   = sy_q - SY_W'(rdata_q) + SY_W'(sample_q);
      sxy_d  = sxy_q - SXY_W'(sy_q) + SXY_W'(sample_q) * $signed(SXY_W'(WINDOW));
      oldest_d = (oldest_q == SLOT_W'(WINDOW - 1)) ? '0 : oldest_q + SLOT_W'(1);
    end
  end

  assign num_full = (SXY_W + WIN_LOG + 1)'(sxy_q) * $signed((SXY_W + WIN_LOG + 1)'(WINDOW))
                  - (SXY_W + WIN_LOG + 1)'(sy_q * $signed({1'b0, sx}));
  assign a_val = prod_q - A_W'(num_q * $signed({1'b0, sx}));

  assign busy_o          = (state_q != F_IDLE);
  assign q_push_o        = (state_q == F_AFIN) && !q_full_i;
  assign q_data_o.num    = num_q;
  assign q_data_o.a      = a_val;
  assign q_data_o.den    = den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      fill_q   <= '0;
      oldest_q <= '0;
      sy_q     <= '0;
      sxy_q    <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: if (push) state_q <= F_SUM;
        F_SUM: begin
          fill_q   <= fill_d;
          oldest_q <= oldest_d;
          sy_q     <= sy_d;
          sxy_q    <= sxy_d;
          state_q  <= F_NUM;
        end
        F_NUM:  state_q <= F_PROD;
        F_PROD: state_q <= F_AFIN;
        F_AFIN: if (!q_full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push) sample_q <= sample_i;
    if (state_q == F_NUM) num_q <= NUM_W'(num_full);
    if (state_q == F_PROD) prod_q <= A_W'(sy_q * $signed({1'b0, den}));
  end

  // Window store: one write port, one registered read of the oldest slot.
  always_ff @(posedge clk_i) begin
    if (state_q == F_SUM) mem[wr_addr] <= sample_q;
    rdata_q <= mem[oldest_q];
  end

endmodule

FILE: rtl/core/swlf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlf_queue
// Two-entry job queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module swlf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swlf_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output swlf_pkg::job_t data_o,
  output logic           empty_o
);
  import swlf_pkg::*;

  job_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= data_i;
  end

endmodule

FILE: rtl/core/swlf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swlf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [swlf_pkg::DVD_W-1:0]    dividend_i,
  input  logic [swlf_pkg::DVS_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [swlf_pkg::RESULT_W-1:0] quotient_o
);
  import swlf_pkg::*;

  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   shifted, trial;

  assign shifted    = {rem_q, quo_q[DVD_W-1]};
  assign trial      = shifted - {1'b0, dvs_q};
  assign done_o     = (cnt_q == '0);
  assign quotient_o = quo_q[RESULT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DVD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!trial[DVS_W]) begin
        rem_q <= trial[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/swlf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlf_back
// Runs the slope and intercept divisions and holds the result beat.
// ----------------------------------------------------------------------------
module swlf_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  swlf_pkg::job_t                       q_data_i,
  output logic                                 q_pop_o,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [swlf_pkg::RESULT_W-1:0] slope_o,
  output logic signed [swlf_pkg::RESULT_W-1:0] intercept_o
);
  import swlf_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_WAIT} state_e;

  state_e              state_q;
  logic                out_valid_q, out_valid_d;
  logic                neg_s_q, neg_i_q;
  logic [NUM_W-1:0]    mag_s;
  logic [A_W-1:0]      mag_i;
  logic                start;
  logic                done_s, done_i;
  logic [RESULT_W-1:0] quo_s, quo_i;
  logic                out_free;

  assign mag_s   = q_data_i.num[NUM_W-1] ? NUM_W'(-q_data_i.num) : NUM_W'(q_data_i.num);
  assign mag_i   = q_data_i.a[A_W-1] ? A_W'(-q_data_i.a) : A_W'(q_data_i.a);
  assign start   = (state_q == B_IDLE) && !q_empty_i;
  assign q_pop_o = start;
  assign out_free = !out_valid_q || pop;
  assign empty   = !out_valid_q;

  // The result flag drops when its beat leaves and rises when a finished
  // job moves into the output register.
  assign out_valid_d = (out_valid_q && !pop) || (state_q == B_WAIT && out_free);

  swlf_div u_div_slope (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (DVD_W'({mag_s, {FRAC_W{1'b0}}})),
    .divisor_i  (DVS_W'(q_data_i.den)),
    .done_o     (done_s),
    .quotient_o (quo_s)
  );

  // The intercept divisor is WINDOW times the slope divisor.
  swlf_div u_div_icpt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i ({mag_i, {FRAC_W{1'b0}}}),
    .divisor_i  (DVS_W'(q_data_i.den) * DVS_W'(WINDOW)),
    .done_o     (done_i),
    .quotient_o (quo_i)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        B_IDLE: if (start) state_q <= B_RUN;
        B_RUN:  if (done_s && done_i) state_q <= B_WAIT;
        B_WAIT: if (out_free) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      neg_s_q <= q_data_i.num[NUM_W-1];
      neg_i_q <= q_data_i.a[A_W-1];
    end
    if (state_q == B_WAIT && out_free) begin
      slope_o     <= neg_s_q ? -$signed(quo_s) : $signed(quo_s);
      intercept_o <= neg_i_q ? -$signed(quo_i) : $signed(quo_i);
    end
  end

endmodule

FILE: rtl/core/sliding_window_linear_fit.sv
`timescale 1ns / 1ps
// Path: an accepted sample passes through the front end, the job queue, the bit-serial
// dividers and the result register, in that order, before its result beat is offered.
// The sample rate is set by the bit-serial dividers; the queue lets the front end run ahead.
// Reset: rst_ni clears the fill count, sums, queue and result flag at once.
// ----------------------------------------------------------------------------
// sliding_window_linear_fit
// Least-squares line fit over a sliding window of signed samples.
// ----------------------------------------------------------------------------
module sliding_window_linear_fit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [swlf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [swlf_pkg::RESULT_W-1:0] slope_o,
  output logic signed [swlf_pkg::RESULT_W-1:0] intercept_o
);
  import swlf_pkg::*;

  // The front end updates the window store and running sums, then forms the
  // slope numerator and intercept numerator in its F_NUM, F_PROD and F_AFIN states. It
  // stays busy (full high) until its job enters the queue.
  logic q_push, q_full, q_pop, q_empty, front_busy;
  job_t q_in, q_out;

  assign full = front_busy;

  swlf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .sample_i (sample_i),
    .busy_o   (front_busy),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_in)
  );

  // The queue lets the front end take a new sample while the dividers work.
  swlf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // The back end divides both numerators in parallel and parks the result
  // beat in an output register; a finished job waits in B_WAIT while an unread beat holds it.
  swlf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .slope_o     (slope_o),
    .intercept_o (intercept_o)
  );

endmodule

FILE: rtl/core/swlf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlf_checker
// Port-level checks of the sliding window fit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_linear_fit_macros.svh"

module swlf_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 push,
  input logic                                 full,
  input logic signed [swlf_pkg::SAMPLE_W-1:0] sample_i,
  input logic                                 empty,
  input logic                                 pop,
  input logic signed [swlf_pkg::RESULT_W-1:0] slope_o,
  input logic signed [swlf_pkg::RESULT_W-1:0] intercept_o
);
  logic [3:0] pend_q;
  logic       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  // Count of samples taken whose result beat has not yet left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(acc_in) - 4'(acc_out);
    end
  end

  `SWLF_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(slope_o) && $stable(intercept_o), "result beat changed while waiting")
  `SWLF_ASSERT_NXT(a_busy, acc_in, full, "front end took a sample without going busy")
  `SWLF_ASSERT_NOW(a_nophantom, pend_q == 4'd0, empty, "result beat without a pending sample")
  `SWLF_ASSERT_NOW(a_bound, 1'b1, pend_q <= 4'd5, "more samples in flight than the design can hold")

endmodule

bind sliding_window_linear_fit swlf_checker u_swlf_checker (.*);
